/* sv/tdau_pkg.sv */
// Package for the temperature display and alarm unit.
// Holds widths, register indexes, scale constants, segment patterns and the
// pipeline struct shared by the stage modules. No dependencies.
package tdau_pkg;

   // Converter sample and register widths
   localparam int SAMPLE_BITS   = 10;
   localparam int OFFSET_W      = 10;
   localparam int THRESHOLD_W   = 8;
   localparam int PERIOD_W      = 7;
   localparam int TEMP_W        = 8;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 10;

   // Width of |sample - offset|
   localparam int DIFF_W = (SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W;

   // Scale 489/2000 as a rounded-up reciprocal; exact for any diff below 2^23/2000
   localparam int            SCALE_SHIFT = 23;
   localparam int            SCALE_W     = 21;
   localparam longint unsigned SCALE_NUM = 64'd489;
   localparam longint unsigned SCALE_DEN = 64'd2000;
   localparam logic [SCALE_W-1:0] SCALE_MULT =
      SCALE_W'((SCALE_NUM * (64'd1 << SCALE_SHIFT) + SCALE_DEN - 64'd1) / SCALE_DEN);
   localparam int PROD_W = DIFF_W + SCALE_W;
   localparam int QUOT_W = PROD_W - SCALE_SHIFT;
   localparam logic [TEMP_W-1:0] TEMP_MAX = '1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_OFFSET     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_EVERY    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_EVERY     = 2'd3;

   // Register reset values
   localparam logic [OFFSET_W-1:0]    ZERO_OFFSET_RST     = 10'd205;
   localparam logic [THRESHOLD_W-1:0] ALARM_THRESHOLD_RST = 8'd100;
   localparam logic [PERIOD_W-1:0]    SAMPLE_EVERY_RST    = 7'd10;
   localparam logic [PERIOD_W-1:0]    ALARM_EVERY_RST     = 7'd100;

   // Display digit positions
   localparam logic [1:0] POS_HUNDREDS = 2'd0;
   localparam logic [1:0] POS_TENS     = 2'd1;
   localparam logic [1:0] POS_ONES     = 2'd2;

   // Active-low segment patterns
   localparam logic [7:0] SEG_MINUS = 8'hBF;
   localparam logic [7:0] SEG_BLANK = 8'hFF;

   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      case (digit)
         4'd0:    pat = 8'hC0;
         4'd1:    pat = 8'hF9;
         4'd2:    pat = 8'hA4;
         4'd3:    pat = 8'hB0;
         4'd4:    pat = 8'h99;
         4'd5:    pat = 8'h92;
         4'd6:    pat = 8'h82;
         4'd7:    pat = 8'hF8;
         4'd8:    pat = 8'h80;
         4'd9:    pat = 8'h90;
         default: pat = SEG_BLANK;
      endcase
      return pat;
   endfunction

   // Sample stage to display stage
   typedef struct packed {
      logic              valid;
      logic              sample_fire;
      logic              alarm_fire;
      logic              below_zero;
      logic [TEMP_W-1:0] temperature;
   } sample_pipe_type;

endpackage

/* sv/tdau_req_if.sv */
// Input channel of the temperature display and alarm unit: one timer tick
// with its converter sample. Depends on tdau_pkg.
interface tdau_req_if;
   logic                              valid;
   logic                              ready;
   logic [tdau_pkg::SAMPLE_BITS-1:0]  adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

/* sv/tdau_rsp_if.sv */
// Result channel of the temperature display and alarm unit: one display and
// indicator update per tick. No dependencies.
interface tdau_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] segments;
   logic [2:0] digit_select;
   logic       sample_blink;
   logic       alarm;

   modport source (output valid, output segments, output digit_select,
                   output sample_blink, output alarm, input ready);
   modport sink   (input valid, input segments, input digit_select,
                   input sample_blink, input alarm, output ready);
endinterface

/* sv/tdau_sample_stage.sv */
// First stage: sample and alarm period counters, offset subtraction and the
// scaled temperature product. Depends on tdau_pkg.
module tdau_sample_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                take,
   input  logic                                drain,
   input  logic [tdau_pkg::SAMPLE_BITS-1:0]    adc_sample,
   input  logic [tdau_pkg::OFFSET_W-1:0]       zero_offset,
   input  logic [tdau_pkg::PERIOD_W-1:0]       sample_every,
   input  logic [tdau_pkg::PERIOD_W-1:0]       alarm_every,
   output tdau_pkg::sample_pipe_type           pipe
);
   import tdau_pkg::*;

   logic [PERIOD_W-1:0] sample_count_ff, sample_count_in;
   logic [PERIOD_W-1:0] alarm_count_ff, alarm_count_in;
   logic [PERIOD_W:0]   sample_sum, alarm_sum;
   logic                sample_fire, alarm_fire;
   logic [DIFF_W-1:0]   sample_ext, offset_ext, diff;
   logic                below;
   logic [PROD_W-1:0]   product;
   logic [QUOT_W-1:0]   quotient;
   logic [TEMP_W-1:0]   temp_sat;
   sample_pipe_type     pipe_ff, pipe_in;

   // Period counters fire once the incremented count reaches the period
   always_comb begin
      sample_sum      = {1'b0, sample_count_ff} + (PERIOD_W+1)'(1);
      alarm_sum       = {1'b0, alarm_count_ff} + (PERIOD_W+1)'(1);
      sample_fire     = sample_sum >= {1'b0, sample_every};
      alarm_fire      = alarm_sum >= {1'b0, alarm_every};
      sample_count_in = sample_fire ? '0 : sample_sum[PERIOD_W-1:0];
      alarm_count_in  = alarm_fire ? '0 : alarm_sum[PERIOD_W-1:0];
   end

   // Magnitude of the offset-corrected sample, then scale and saturate
   always_comb begin
      sample_ext = DIFF_W'(adc_sample);
      offset_ext = DIFF_W'(zero_offset);
      below      = sample_ext < offset_ext;
      diff       = below ? (offset_ext - sample_ext) : (sample_ext - offset_ext);
      product    = PROD_W'(diff) * PROD_W'(SCALE_MULT);
      quotient   = product[PROD_W-1:SCALE_SHIFT];
      temp_sat   = (quotient > QUOT_W'(TEMP_MAX)) ? TEMP_MAX : quotient[TEMP_W-1:0];
   end

   // Stage register: load on transfer, drop valid once passed on
   always_comb begin
      pipe_in = pipe_ff;
      if (take) begin
         pipe_in.valid       = 1'b1;
         pipe_in.sample_fire = sample_fire;
         pipe_in.alarm_fire  = alarm_fire;
         pipe_in.below_zero  = below;
         pipe_in.temperature = temp_sat;
      end else if (drain) begin
         pipe_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= '0;
         alarm_count_ff  <= '0;
         pipe_ff.valid   <= 1'b0;
      end else begin
         if (take) begin
            sample_count_ff <= sample_count_in;
            alarm_count_ff  <= alarm_count_in;
         end
         pipe_ff.valid <= pipe_in.valid;
      end
      pipe_ff.sample_fire <= pipe_in.sample_fire;
      pipe_ff.alarm_fire  <= pipe_in.alarm_fire;
      pipe_ff.below_zero  <= pipe_in.below_zero;
      pipe_ff.temperature <= pipe_in.temperature;
   end

   assign pipe = pipe_ff;

endmodule

/* sv/tdau_display_stage.sv */
// Second stage: temperature and alarm state, display multiplexing and the
// result register. Depends on tdau_pkg and tdau_rsp_if.
module tdau_display_stage (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               move,
   input  tdau_pkg::sample_pipe_type          pipe,
   input  logic [tdau_pkg::THRESHOLD_W-1:0]   alarm_threshold,
   tdau_rsp_if.source                         rsp_chan
);
   import tdau_pkg::*;

   logic [TEMP_W-1:0] temperature_ff, temperature_in;
   logic              below_zero_ff, below_zero_in;
   logic [TEMP_W-1:0] frame_temp_ff, frame_temp_in;
   logic              frame_below_ff, frame_below_in;
   logic [1:0]        digit_pos_ff, digit_pos_in;
   logic              blink_ff, blink_in;
   logic              alarm_ff, alarm_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        segments_ff, segments_in;
   logic [2:0]        digit_sel_ff, digit_sel_in;
   logic [1:0]        hundreds;
   logic [6:0]        rem;
   logic [14:0]       tens_prod;
   logic [3:0]        tens, ones;

   // Sample update, then alarm update on the refreshed temperature
   always_comb begin
      temperature_in = pipe.sample_fire ? pipe.temperature : temperature_ff;
      below_zero_in  = pipe.sample_fire ? pipe.below_zero : below_zero_ff;
      blink_in       = pipe.sample_fire ? ~blink_ff : blink_ff;
      alarm_in       = alarm_ff;
      if (pipe.alarm_fire) begin
         alarm_in = (temperature_in >= alarm_threshold) ? ~alarm_ff : 1'b0;
      end
   end

   // Advance the digit position and latch the frame at its start
   always_comb begin
      digit_pos_in   = (digit_pos_ff >= POS_ONES) ? POS_HUNDREDS : digit_pos_ff + 2'd1;
      frame_temp_in  = (digit_pos_in == POS_HUNDREDS) ? temperature_in : frame_temp_ff;
      frame_below_in = (digit_pos_in == POS_HUNDREDS) ? below_zero_in : frame_below_ff;
   end

   // Split the frame temperature into decimal digits
   always_comb begin
      if (frame_temp_in >= TEMP_W'(200)) begin
         hundreds = 2'd2;
      end else if (frame_temp_in >= TEMP_W'(100)) begin
         hundreds = 2'd1;
      end else begin
         hundreds = 2'd0;
      end
      rem       = 7'(frame_temp_in - TEMP_W'(hundreds) * TEMP_W'(100));
      tens_prod = 15'(rem) * 15'd205;
      tens      = tens_prod[14:11];
      ones      = 4'(rem - 7'(tens) * 7'd10);
   end

   // Select the pattern for the active digit
   always_comb begin
      case (digit_pos_in)
         POS_HUNDREDS: begin
            segments_in  = frame_below_in ? SEG_MINUS : seg_pattern(4'(hundreds));
            digit_sel_in = 3'b001;
         end
         POS_TENS: begin
            segments_in  = seg_pattern(tens);
            digit_sel_in = 3'b010;
         end
         POS_ONES: begin
            segments_in  = seg_pattern(ones);
            digit_sel_in = 3'b100;
         end
         default: begin
            segments_in  = SEG_BLANK;
            digit_sel_in = 3'b000;
         end
      endcase
   end

   // Result valid: set on transfer in, clear on transfer out
   assign rsp_valid_in = move ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         temperature_ff <= '0;
         below_zero_ff  <= 1'b1;
         frame_temp_ff  <= '0;
         frame_below_ff <= 1'b1;
         digit_pos_ff   <= POS_ONES;
         blink_ff       <= 1'b0;
         alarm_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (move) begin
            temperature_ff <= temperature_in;
            below_zero_ff  <= below_zero_in;
            frame_temp_ff  <= frame_temp_in;
            frame_below_ff <= frame_below_in;
            digit_pos_ff   <= digit_pos_in;
            blink_ff       <= blink_in;
            alarm_ff       <= alarm_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (move) begin
         segments_ff  <= segments_in;
         digit_sel_ff <= digit_sel_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.segments     = segments_ff;
   assign rsp_chan.digit_select = digit_sel_ff;
   assign rsp_chan.sample_blink = blink_ff;
   assign rsp_chan.alarm        = alarm_ff;

endmodule

/* sv/temperature_display_alarm_unit.sv */
// Temperature display and alarm unit: one result per tick, two-stage pipeline.
// Stages: counters and scaling multiply into the input register, then state update
// and segment select into the result register.
// Throughput: 1 tick per cycle; the pipeline stalls only while a result waits.
// Reset (synchronous, active high): registers to their defaults, display at the
// last digit so the first tick opens a frame, no result pending.
module temperature_display_alarm_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   tdau_req_if.sink                              req_chan,
   tdau_rsp_if.source                            rsp_chan,
   input  logic                                  csr_write_en,
   input  logic [tdau_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tdau_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import tdau_pkg::*;

   logic [OFFSET_W-1:0]    zero_offset_ff;
   logic [THRESHOLD_W-1:0] alarm_threshold_ff;
   logic [PERIOD_W-1:0]    sample_every_ff;
   logic [PERIOD_W-1:0]    alarm_every_ff;
   sample_pipe_type        pipe;
   logic                   advance, take, move;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff     <= ZERO_OFFSET_RST;
         alarm_threshold_ff <= ALARM_THRESHOLD_RST;
         sample_every_ff    <= SAMPLE_EVERY_RST;
         alarm_every_ff     <= ALARM_EVERY_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ZERO_OFFSET:     zero_offset_ff     <= csr_write_data[OFFSET_W-1:0];
            CSR_ALARM_THRESHOLD: alarm_threshold_ff <= csr_write_data[THRESHOLD_W-1:0];
            CSR_SAMPLE_EVERY:    sample_every_ff    <= csr_write_data[PERIOD_W-1:0];
            CSR_ALARM_EVERY:     alarm_every_ff     <= csr_write_data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline flow: advance when the result slot is free or being taken
   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign move           = pipe.valid && advance;
   assign req_chan.ready = !reset && (!pipe.valid || advance);
   assign take           = req_chan.valid && req_chan.ready;

   tdau_sample_stage u_sample (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .drain        (move),
      .adc_sample   (req_chan.adc_sample),
      .zero_offset  (zero_offset_ff),
      .sample_every (sample_every_ff),
      .alarm_every  (alarm_every_ff),
      .pipe         (pipe)
   );

   tdau_display_stage u_display (
      .clock           (clock),
      .reset           (reset),
      .move            (move),
      .pipe            (pipe),
      .alarm_threshold (alarm_threshold_ff),
      .rsp_chan        (rsp_chan)
   );

endmodule

/* test/tdau_display_checker.sv */
`timescale 1ns / 1ps
// Display checker for the temperature display and alarm unit: tracks register
// writes, predicts one display word per accepted tick and compares it with the
// result channel. Depends on tdau_pkg, tdau_req_if and tdau_rsp_if.
module tdau_display_checker (
   input  logic                             clock,
   input  logic                             reset,
   tdau_req_if                              req_mon,
   tdau_rsp_if                              rsp_mon,
   input  logic                             csr_write_en,
   input  logic [tdau_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tdau_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                               failures,
   output int                               words_pending,
   output int                               words_checked
);
   import tdau_pkg::*;

   // Scale 0.2445 as an exact ratio
   localparam int unsigned SCALE_TIMES = 489;
   localparam int unsigned SCALE_PER   = 2000;

   // Active-low glyphs for the decimal digits
   localparam logic [7:0] DIGIT_GLYPH [10] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
   };

   typedef struct packed {
      logic [7:0] segments;
      logic [2:0] digit_select;
      logic       sample_blink;
      logic       alarm;
   } display_word_type;

   // Register copies
   logic [OFFSET_W-1:0]    cal_offset;
   logic [THRESHOLD_W-1:0] alarm_limit;
   logic [PERIOD_W-1:0]    sample_period;
   logic [PERIOD_W-1:0]    alarm_period;

   // Predicted block state
   logic [PERIOD_W-1:0] sample_ticks;
   logic [PERIOD_W-1:0] alarm_ticks;
   logic [TEMP_W-1:0]   live_temp;
   logic                live_negative;
   logic [TEMP_W-1:0]   frame_temp;
   logic                frame_negative;
   logic [1:0]          digit_pos;
   logic                blink;
   logic                alarm_out;

   display_word_type expected_words [$];
   int               mismatch_count;
   int               compared_count;

   function automatic void clear_display_state();
      cal_offset     = ZERO_OFFSET_RST;
      alarm_limit    = ALARM_THRESHOLD_RST;
      sample_period  = SAMPLE_EVERY_RST;
      alarm_period   = ALARM_EVERY_RST;
      sample_ticks   = '0;
      alarm_ticks    = '0;
      live_temp      = '0;
      live_negative  = 1'b1;
      frame_temp     = '0;
      frame_negative = 1'b1;
      digit_pos      = POS_ONES;
      blink          = 1'b0;
      alarm_out      = 1'b0;
   endfunction

   function automatic void apply_csr_write(input logic [CSR_INDEX_W-1:0] index,
                                           input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_ZERO_OFFSET:     cal_offset    = data[OFFSET_W-1:0];
         CSR_ALARM_THRESHOLD: alarm_limit   = data[THRESHOLD_W-1:0];
         CSR_SAMPLE_EVERY:    sample_period = data[PERIOD_W-1:0];
         CSR_ALARM_EVERY:     alarm_period  = data[PERIOD_W-1:0];
         default: ;
      endcase
   endfunction

   // Advance the display state by one tick and return the word it shows
   function automatic display_word_type predict_tick(input logic [SAMPLE_BITS-1:0] adc_value);
      display_word_type  word;
      logic [PERIOD_W:0] next_count;
      logic [DIFF_W-1:0] distance;
      int unsigned       degrees;
      logic [7:0]        glyph;

      // Sample period: latch, scale, toggle the blink level
      next_count = {1'b0, sample_ticks} + (PERIOD_W+1)'(1);
      if (next_count >= {1'b0, sample_period}) begin
         sample_ticks  = '0;
         live_negative = adc_value < cal_offset;
         distance      = live_negative ? cal_offset - adc_value : adc_value - cal_offset;
         degrees       = 32'(distance) * SCALE_TIMES / SCALE_PER;
         live_temp     = (degrees > 32'(TEMP_MAX)) ? TEMP_MAX : degrees[TEMP_W-1:0];
         blink         = ~blink;
      end else begin
         sample_ticks = next_count[PERIOD_W-1:0];
      end

      // Alarm period: blink while hot, clear otherwise
      next_count = {1'b0, alarm_ticks} + (PERIOD_W+1)'(1);
      if (next_count >= {1'b0, alarm_period}) begin
         alarm_ticks = '0;
         alarm_out   = (live_temp >= alarm_limit) ? ~alarm_out : 1'b0;
      end else begin
         alarm_ticks = next_count[PERIOD_W-1:0];
      end

      // Display: advance the digit, latch a new frame on the first digit
      digit_pos = (digit_pos >= POS_ONES) ? POS_HUNDREDS : digit_pos + 2'd1;
      if (digit_pos == POS_HUNDREDS) begin
         frame_temp     = live_temp;
         frame_negative = live_negative;
      end
      case (digit_pos)
         POS_HUNDREDS: glyph = frame_negative ? SEG_MINUS
                                              : DIGIT_GLYPH[4'(frame_temp / 100)];
         POS_TENS:     glyph = DIGIT_GLYPH[4'((frame_temp % 100) / 10)];
         default:      glyph = DIGIT_GLYPH[4'(frame_temp % 10)];
      endcase

      word.segments     = glyph;
      word.digit_select = 3'b001 << digit_pos;
      word.sample_blink = blink;
      word.alarm        = alarm_out;
      return word;
   endfunction

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   initial begin
      clear_display_state();
      mismatch_count = 0;
      compared_count = 0;
      failures       = 0;
      words_pending  = 0;
      words_checked  = 0;
   end

   // Track writes, predict on each tick transfer, compare on each result transfer
   always @(posedge clock) begin : watch
      display_word_type want;
      display_word_type got;
      if (reset) begin
         clear_display_state();
         expected_words.delete();
      end else begin
         if (csr_write_en)
            apply_csr_write(csr_index, csr_write_data);
         if (req_mon.valid && req_mon.ready)
            expected_words.push_back(predict_tick(req_mon.adc_sample));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.segments     = rsp_mon.segments;
            got.digit_select = rsp_mon.digit_select;
            got.sample_blink = rsp_mon.sample_blink;
            got.alarm        = rsp_mon.alarm;
            if (expected_words.size() == 0) begin
               $error("display word 0x%0h with no tick waiting for it", got);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("segments", want.segments, got.segments);
               check_field("digit_select", 8'(want.digit_select), 8'(got.digit_select));
               check_field("sample_blink", 8'(want.sample_blink), 8'(got.sample_blink));
               check_field("alarm", 8'(want.alarm), 8'(got.alarm));
               compared_count++;
            end
         end
      end
      failures      <= mismatch_count;
      words_pending <= expected_words.size();
      words_checked <= compared_count;
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Top of the temperature display and alarm unit testbench: clock, reset, tick
// and register stimulus, output stalls and the verdict. Depends on tdau_pkg,
// the channel interfaces, the unit itself and tdau_display_checker.
module tb_top;
   import tdau_pkg::*;

   localparam int ITEM_GOAL      = 1850;
   localparam int GAP_MAX        = 18;
   localparam int LONG_HOLD      = 90;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int TAIL_CYCLES    = 16;
   localparam int ADC_TOP        = (1 << SAMPLE_BITS) - 1;

   localparam logic [CSR_INDEX_W-1:0] REG_ORDER [4] = '{
      CSR_ZERO_OFFSET, CSR_ALARM_THRESHOLD, CSR_SAMPLE_EVERY, CSR_ALARM_EVERY
   };

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   int failures;
   int words_pending;
   int words_checked;
   int ticks_sent;
   int settings_used;
   int hold_requests;
   int stall_cycles;
   int offset_now;
   int limit_now;
   bit req_burst;

   tdau_req_if req_bus ();
   tdau_rsp_if rsp_bus ();

   temperature_display_alarm_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   tdau_display_checker display_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .failures       (failures),
      .words_pending  (words_pending),
      .words_checked  (words_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // End the run if nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("temperature_display_alarm_unit verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Result side: random stalls, bursts with none, long hold-offs on request
   initial begin : display_sink
      int gap;
      int holds_served;
      bit rsp_burst;
      holds_served = 0;
      rsp_burst    = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if ($urandom_range(0, 29) == 0)
            rsp_burst = ~rsp_burst;
         gap = rsp_burst ? 0 : $urandom_range(0, GAP_MAX);
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Offer one tick after a random gap and hold it until the transfer
   task automatic send_tick(input logic [SAMPLE_BITS-1:0] adc_value);
      int gap;
      if ($urandom_range(0, 29) == 0)
         req_burst = ~req_burst;
      gap = req_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.adc_sample <= adc_value;
      do @(posedge clock); while (!req_bus.ready);
      ticks_sent++;
   endtask

   // Stop offering and wait until every predicted word has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
   endtask

   // Write the registers selected by mask, one per cycle; only call while idle
   task automatic program_regs(input logic [CSR_DATA_W-1:0] offset_data,
                               input logic [CSR_DATA_W-1:0] limit_data,
                               input logic [CSR_DATA_W-1:0] sample_data,
                               input logic [CSR_DATA_W-1:0] alarm_data,
                               input logic [3:0]            mask);
      logic [CSR_DATA_W-1:0] value_of [4];
      value_of[0] = offset_data;
      value_of[1] = limit_data;
      value_of[2] = sample_data;
      value_of[3] = alarm_data;
      for (int i = 0; i < 4; i++) begin
         if (mask[i]) begin
            csr_write_en   <= 1'b1;
            csr_index      <= REG_ORDER[i];
            csr_write_data <= value_of[i];
            @(posedge clock);
         end
      end
      csr_write_en <= 1'b0;
      if (mask[0])
         offset_now = int'(offset_data[OFFSET_W-1:0]);
      if (mask[1])
         limit_now = int'(limit_data[THRESHOLD_W-1:0]);
      settings_used++;
   endtask

   // Period value, mostly short, with the extremes and junk in the upper bits
   function automatic logic [CSR_DATA_W-1:0] pick_period();
      int p;
      case ($urandom_range(0, 9))
         0:       p = 0;
         1:       p = 100;
         2:       p = 127;
         3:       p = $urandom_range(0, 127);
         default: p = $urandom_range(1, 6);
      endcase
      return CSR_DATA_W'(p) | (CSR_DATA_W'($urandom_range(0, 7)) << PERIOD_W);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_limit();
      int t;
      case ($urandom_range(0, 7))
         0:       t = 0;
         1:       t = 255;
         2:       t = $urandom_range(0, 255);
         default: t = $urandom_range(0, 60);
      endcase
      return CSR_DATA_W'(t) | (CSR_DATA_W'($urandom_range(0, 3)) << THRESHOLD_W);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_offset();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return CSR_DATA_W'(ADC_TOP);
         2:       return ZERO_OFFSET_RST;
         default: return CSR_DATA_W'($urandom_range(0, ADC_TOP));
      endcase
   endfunction

   // Reading shaped around zero, the full scale and the alarm threshold
   function automatic logic [SAMPLE_BITS-1:0] pick_reading();
      int v;
      int span;
      case ($urandom_range(0, 9))
         0: v = ($urandom_range(0, 1) != 0) ? ADC_TOP : 0;
         1, 2: v = offset_now + $urandom_range(0, 8) - 4;
         3, 4: begin
            span = (limit_now * 2000 + 488) / 489 + $urandom_range(0, 8) - 4;
            v = ($urandom_range(0, 3) == 0) ? offset_now - span : offset_now + span;
         end
         default: v = $urandom_range(0, ADC_TOP);
      endcase
      if (v < 0)
         v = 0;
      if (v > ADC_TOP)
         v = ADC_TOP;
      return SAMPLE_BITS'(v);
   endfunction

   initial begin : stimulus
      int phase_len;
      int pause_at;
      int hold_at;
      int phase;
      reset              <= 1'b1;
      csr_write_en       <= 1'b0;
      csr_index          <= CSR_ZERO_OFFSET;
      csr_write_data     <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.adc_sample <= '0;
      hold_requests      <= 0;
      stall_cycles       <= 0;
      ticks_sent    = 0;
      settings_used = 1;
      offset_now    = int'(ZERO_OFFSET_RST);
      limit_now     = int'(ALARM_THRESHOLD_RST);
      req_burst     = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: first frame shows the minus sign before any sample
      send_tick('0);
      send_tick(SAMPLE_BITS'(ADC_TOP));
      send_tick(10'd205);
      drain();

      // Offset zero, threshold zero, every tick sampled, alarm toggling
      program_regs(10'd0, 10'd0, 10'd1, 10'd1, 4'b1111);
      send_tick(SAMPLE_BITS'(ADC_TOP));
      send_tick('0);
      send_tick(10'd409);
      send_tick(10'd512);
      drain();

      // Threshold right at the top reading, then one above it
      program_regs(10'd0, 10'd250, 10'd1, 10'd1, 4'b0010);
      send_tick(SAMPLE_BITS'(ADC_TOP));
      send_tick(SAMPLE_BITS'(ADC_TOP));
      send_tick(SAMPLE_BITS'(ADC_TOP));
      drain();
      program_regs(10'd0, 10'd251, 10'd1, 10'd1, 4'b0010);
      send_tick(SAMPLE_BITS'(ADC_TOP));
      send_tick(SAMPLE_BITS'(ADC_TOP));
      drain();

      // Offset at full scale, sample period masked to zero, alarm period zero, threshold masked to 255
      program_regs(10'h3FF, 10'h3FF, 10'h080, 10'd0, 4'b1111);
      send_tick('0);
      send_tick(SAMPLE_BITS'(ADC_TOP));
      send_tick(10'd1022);
      drain();

      // Lower the sample period below the running count
      program_regs(10'd512, 10'd10, 10'd100, 10'd100, 4'b1111);
      repeat (6) send_tick(pick_reading());
      drain();
      program_regs(10'd512, 10'd10, 10'd3, 10'd100, 4'b0100);
      send_tick(10'd700);
      send_tick(10'd300);
      drain();

      // Random phases, each under a fresh register setting
      phase = 0;
      while (ticks_sent < ITEM_GOAL) begin
         program_regs(pick_offset(), pick_limit(), pick_period(), pick_period(),
                      4'($urandom_range(1, 15)));
         phase_len = $urandom_range(20, 120);
         pause_at  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, phase_len - 1) : -1;
         hold_at   = (phase == 2 || $urandom_range(0, 6) == 0) ? 4 : -1;
         for (int k = 0; k < phase_len; k++) begin
            if (k == hold_at)
               hold_requests <= hold_requests + 1;
            if (k == pause_at)
               drain();
            send_tick(pick_reading());
         end
         drain();
         phase++;
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d ticks under %0d register settings; compared %0d display words,",
               ticks_sent, settings_used, words_checked);
      $display("with %0d long output hold-offs.", hold_requests);
      if (failures == 0 && words_pending == 0)
         $display("temperature_display_alarm_unit verification clean");
      else
         $display("temperature_display_alarm_unit verification failed");
      $finish;
   end

endmodule

/* files.f */
sv/tdau_pkg.sv
sv/tdau_req_if.sv
sv/tdau_rsp_if.sv
sv/tdau_sample_stage.sv
sv/tdau_display_stage.sv
sv/temperature_display_alarm_unit.sv
test/tdau_display_checker.sv
test/tb_top.sv
